FILE: sv/smpd_pkg.sv
`default_nettype none

package smpd_pkg;

  localparam int unsigned MarkerBytes = 4;
  localparam int unsigned MatchW      = $clog2(MarkerBytes);
  localparam int unsigned ByteW       = 8;
  localparam int unsigned PosW        = 6;
  localparam int unsigned MarkerW     = MarkerBytes * ByteW;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [PosW-1:0]  pos_t;

  // Store write request from the marker hunter to the packet store.
  typedef struct packed {
    logic  en;
    pos_t  addr;
    byte_t data;
  } wr_req_t;

endpackage

`default_nettype wire

FILE: sv/smpd_rx_if.sv
`default_nettype none

interface smpd_rx_if import smpd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/smpd_pkt_if.sv
`default_nettype none

interface smpd_pkt_if import smpd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t packet_byte;
  pos_t  byte_position;
  logic  last_of_packet;

  modport source (output valid, output packet_byte, output byte_position,
                  output last_of_packet, input ready);
  modport sink   (input valid, input packet_byte, input byte_position,
                  input last_of_packet, output ready);
endinterface

`default_nettype wire

FILE: sv/start_marker_packet_deframer.sv
// Channel   Dir  Payload                                       Handshake
// rx_i      in   rx_byte                                       valid/ready
// pkt_o     out  packet_byte, byte_position, last_of_packet    valid/ready
// cfg       in   cfg_wdata_i (start marker)                    cfg_we_i
//
// A received word is taken every cycle while hunting or filling and no packet is
// being emitted; it passes through the input register, then updates the counters
// and the store. A completed packet leaves as PACKET_LEN words at one per cycle,
// unless pkt_o stalls, via the store's single read port and two register stages.
// The input register is not drained from the cycle after the packet's last word
// until the last store read has issued; rx_i is held off while it is full.
// Reset clears counters and marker; the store needs no clearing.
`default_nettype none

module start_marker_packet_deframer import smpd_pkg::*; #(
  parameter int unsigned PACKET_LEN = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  smpd_rx_if.sink                 rx_i,
  smpd_pkt_if.source              pkt_o,
  input  wire logic               cfg_we_i,
  input  wire logic [MarkerW-1:0] cfg_wdata_i
);

  logic [MarkerW-1:0] marker_q;
  wr_req_t            wr_req;
  logic               start;
  logic               busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= '0;
    end else if (cfg_we_i) begin
      marker_q <= cfg_wdata_i;
    end
  end

  smpd_hunt #(.PACKET_LEN(PACKET_LEN)) u_hunt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_i     (rx_i),
    .marker_i (marker_q),
    .busy_i   (busy),
    .wr_o     (wr_req),
    .start_o  (start)
  );

  smpd_burst #(.PACKET_LEN(PACKET_LEN)) u_burst (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr_req),
    .start_i (start),
    .busy_o  (busy),
    .pkt_o   (pkt_o)
  );

endmodule

`default_nettype wire

FILE: sv/smpd_hunt.sv
`default_nettype none

module smpd_hunt import smpd_pkg::*; #(
  parameter int unsigned PACKET_LEN = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  smpd_rx_if.sink                   rx_i,
  input  wire logic [MarkerW-1:0]   marker_i,
  input  wire logic                 busy_i,
  output wr_req_t                   wr_o,
  output logic                      start_o
);

  localparam int unsigned FW = $clog2(PACKET_LEN);
  localparam logic [FW-1:0] LastPos   = FW'(PACKET_LEN - 1);
  localparam logic [FW-1:0] FirstLoad = FW'(MarkerBytes);
  localparam logic [MatchW-1:0] LastMatch = MatchW'(MarkerBytes - 1);

  logic                           in_vld_q;
  byte_t                          in_byte_q;
  logic [MatchW-1:0]              match_q, match_d;
  logic [FW-1:0]                  fill_q, fill_d;
  logic                           consume;
  logic                           hunting;
  logic                           hit_cur;
  logic                           hit_first;
  logic [MarkerBytes-1:0][ByteW-1:0] marker;

  assign marker    = marker_i;
  assign consume   = in_vld_q && !busy_i;
  assign rx_i.ready = !in_vld_q || consume;
  assign hunting   = (fill_q == '0);
  assign hit_cur   = (in_byte_q == marker[match_q]);
  assign hit_first = (in_byte_q == marker[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (consume) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_comb begin
    match_d    = match_q;
    fill_d     = fill_q;
    start_o    = 1'b0;
    wr_o.en    = consume;
    wr_o.data  = in_byte_q;
    wr_o.addr  = hunting ? PosW'(match_q) : PosW'(fill_q);
    if (consume) begin
      if (hunting) begin
        if (hit_cur) begin
          if (match_q == LastMatch) begin
            match_d = '0;
            fill_d  = FirstLoad;
          end else begin
            match_d = match_q + MatchW'(1);
          end
        end else begin
          // Simple restart: only a fresh match on marker byte 0 is kept.
          match_d = hit_first ? MatchW'(1) : '0;
        end
      end else if (fill_q == LastPos) begin
        fill_d  = '0;
        start_o = 1'b1;
      end else begin
        fill_d = fill_q + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      fill_q  <= '0;
    end else begin
      match_q <= match_d;
      fill_q  <= fill_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/smpd_burst.sv
`default_nettype none

module smpd_burst import smpd_pkg::*; #(
  parameter int unsigned PACKET_LEN = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire wr_req_t wr_i,
  input  wire logic    start_i,
  output logic         busy_o,
  smpd_pkt_if.source   pkt_o
);

  localparam int unsigned AW = $clog2(PACKET_LEN);
  localparam logic [AW-1:0] LastIdx = AW'(PACKET_LEN - 1);

  byte_t           mem_q [PACKET_LEN];
  logic            emitting_q;
  logic [AW-1:0]   rd_ptr_q;
  logic            rd_vld_q;
  byte_t           rd_data_q;
  pos_t            rd_pos_q;
  logic            rd_last_q;
  logic            o_vld_q;
  byte_t           o_byte_q;
  pos_t            o_pos_q;
  logic            o_last_q;
  logic            o_load;
  logic            issue;

  assign o_load = rd_vld_q && (!o_vld_q || pkt_o.ready);
  assign issue  = emitting_q && (!rd_vld_q || o_load);
  assign busy_o = emitting_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q <= mem_q[rd_ptr_q];
      rd_pos_q  <= PosW'(rd_ptr_q);
      rd_last_q <= (rd_ptr_q == LastIdx);
    end
  end

  // Once the last read has issued the store may take new words again.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitting_q <= 1'b0;
      rd_ptr_q   <= '0;
    end else if (start_i) begin
      emitting_q <= 1'b1;
      rd_ptr_q   <= '0;
    end else if (issue) begin
      if (rd_ptr_q == LastIdx) begin
        emitting_q <= 1'b0;
        rd_ptr_q   <= '0;
      end else begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      if (issue) begin
        rd_vld_q <= 1'b1;
      end else if (o_load) begin
        rd_vld_q <= 1'b0;
      end
      if (o_load) begin
        o_vld_q <= 1'b1;
      end else if (pkt_o.ready) begin
        o_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_load) begin
      o_byte_q <= rd_data_q;
      o_pos_q  <= rd_pos_q;
      o_last_q <= rd_last_q;
    end
  end

  assign pkt_o.valid          = o_vld_q;
  assign pkt_o.packet_byte    = o_byte_q;
  assign pkt_o.byte_position  = o_pos_q;
  assign pkt_o.last_of_packet = o_last_q;

endmodule

`default_nettype wire

FILE: sv/smpd_checker.sv
`default_nettype none

module smpd_checker import smpd_pkg::*; #(
  parameter int unsigned PACKET_LEN = 16
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  pkt_valid_i,
  input wire logic  pkt_ready_i,
  input wire byte_t pkt_byte_i,
  input wire pos_t  pkt_pos_i,
  input wire logic  pkt_last_i
);

  localparam pos_t LastPos = PosW'(PACKET_LEN - 1);

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_i && !pkt_ready_i |=> pkt_valid_i && $stable(pkt_byte_i)
      && $stable(pkt_pos_i) && $stable(pkt_last_i))
    else $error("output word changed while stalled");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_i && pkt_last_i |-> pkt_pos_i == LastPos)
    else $error("last word not at final packet position");

  a_inner_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_i && !pkt_last_i |-> pkt_pos_i < LastPos)
    else $error("non-last word beyond packet length");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_i && pkt_ready_i && !pkt_last_i |=>
      !pkt_valid_i || (pkt_pos_i == $past(pkt_pos_i) + PosW'(1)))
    else $error("burst positions not consecutive");

endmodule

bind start_marker_packet_deframer smpd_checker #(.PACKET_LEN(PACKET_LEN)) u_smpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pkt_valid_i (pkt_o.valid),
  .pkt_ready_i (pkt_o.ready),
  .pkt_byte_i  (pkt_o.packet_byte),
  .pkt_pos_i   (pkt_o.byte_position),
  .pkt_last_i  (pkt_o.last_of_packet)
);

`default_nettype wire
